// ===== hw/rtl/dpi_pkg.sv =====
package dpi_pkg;

	// cordic datapath widths
	localparam int CW     = 24;   // x and y of the rotating vector, Q1.20 with headroom
	localparam int ZW     = 26;   // residual angle, Q3.20 with headroom
	localparam int ITER_W = 5;    // iteration index
	localparam int MAX_ITER = 24; // most cordic iterations run; the arctangent table is zero past index 20

	// angle constants, Q3.20
	localparam logic signed [ZW-1:0] ANG_PI      = 26'sd3294199;
	localparam logic signed [ZW-1:0] ANG_NEG_PI  = -26'sd3294199;
	localparam logic signed [ZW-1:0] ANG_TWO_PI  = 26'sd6588398;
	localparam logic signed [ZW-1:0] ANG_HALF_PI = 26'sd1647099;
	localparam logic signed [ZW-1:0] ANG_NEG_HALF_PI = -26'sd1647099;

	// cordic start magnitude, Q1.20
	localparam logic signed [CW-1:0] CORDIC_K = 24'sd636751;

	// cosine and sine of the current heading
	typedef struct packed {
		logic signed [CW-1:0] c;
		logic signed [CW-1:0] s;
	} sincos_t;

	// arctangent of 2^-i, Q3.20
	function automatic logic signed [ZW-1:0] atan_q20(input logic [ITER_W-1:0] i);
		logic signed [ZW-1:0] a;
		unique case (i)
			5'd0:  a = 26'sd823550;
			5'd1:  a = 26'sd486170;
			5'd2:  a = 26'sd256879;
			5'd3:  a = 26'sd130396;
			5'd4:  a = 26'sd65451;
			5'd5:  a = 26'sd32757;
			5'd6:  a = 26'sd16383;
			5'd7:  a = 26'sd8192;
			5'd8:  a = 26'sd4096;
			5'd9:  a = 26'sd2048;
			5'd10: a = 26'sd1024;
			5'd11: a = 26'sd512;
			5'd12: a = 26'sd256;
			5'd13: a = 26'sd128;
			5'd14: a = 26'sd64;
			5'd15: a = 26'sd32;
			5'd16: a = 26'sd16;
			5'd17: a = 26'sd8;
			5'd18: a = 26'sd4;
			5'd19: a = 26'sd2;
			5'd20: a = 26'sd1;
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

// ===== hw/rtl/dpi_cordic.sv =====
module dpi_cordic #(
	parameter int ITERATIONS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic signed [23:0]          angle,
	output logic                        done,
	output dpi_pkg::sincos_t            result
);
	import dpi_pkg::*;

	localparam int RUN = (ITERATIONS < MAX_ITER) ? ITERATIONS : MAX_ITER;
	localparam logic [ITER_W-1:0] LAST = ITER_W'(RUN - 1);

	logic                    busy_q;
	logic                    done_q;
	logic [ITER_W-1:0]       iter_q;
	logic signed [CW-1:0]    x_q;
	logic signed [CW-1:0]    y_q;
	logic signed [ZW-1:0]    z_q;
	logic                    flip_q;

	logic signed [ZW-1:0]    h0;
	logic signed [ZW-1:0]    h1;
	logic signed [ZW-1:0]    z0;
	logic                    flip0;
	logic signed [CW-1:0]    dx;
	logic signed [CW-1:0]    dy;
	logic signed [ZW-1:0]    atan;

	// fold the heading into [-pi, pi], then into [-pi/2, pi/2] with a flip
	always_comb begin
		h0 = {{(ZW-24){angle[23]}}, angle};
		h1 = h0;
		if (h0 > ANG_PI) begin
			h1 = h0 - ANG_TWO_PI;
		end else if (h0 < ANG_NEG_PI) begin
			h1 = h0 + ANG_TWO_PI;
		end
		z0    = h1;
		flip0 = 1'b0;
		if (h1 > ANG_HALF_PI) begin
			z0    = h1 - ANG_PI;
			flip0 = 1'b1;
		end else if (h1 < ANG_NEG_HALF_PI) begin
			z0    = h1 + ANG_PI;
			flip0 = 1'b1;
		end
	end

	// one micro-rotation per cycle
	assign dx   = y_q >>> iter_q;
	assign dy   = x_q >>> iter_q;
	assign atan = atan_q20(iter_q);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				iter_q <= '0;
			end else if (busy_q) begin
				if (iter_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					iter_q <= iter_q + 1'b1;
				end
			end
		end
	end

	// vector and residual angle
	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= CORDIC_K;
			y_q    <= '0;
			z_q    <= z0;
			flip_q <= flip0;
		end else if (busy_q) begin
			if (!z_q[ZW-1]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - atan;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + atan;
			end
		end
	end

	// undo the half-turn fold
	assign result.c = flip_q ? -x_q : x_q;
	assign result.s = flip_q ? -y_q : y_q;
	assign done     = done_q;

endmodule

// ===== hw/rtl/differential_drive_pose_integrator.sv =====
// Differential-drive pose integrator, one Euler odometry step per beat.
// Input channel: cmd_left / cmd_right (signed Q4.12 wheel speeds) with
// in_valid / in_stall. Output channel: pos_x, pos_y (Q16.16, saturating)
// and heading (Q3.20) with out_valid / out_stall.
// Each input beat advances the stored pose with the wheel speeds of the
// previous beat, then stores the new commands clamped to +-max_wheel_speed.
// Datapath: sin/cos of the heading comes from an iterative cordic, one
// micro-rotation per cycle, followed by nine steps on one shared 18x25
// multiply-accumulate unit. in_stall is high while the block works, from
// an accepted beat until its result is loaded into the output register,
// so no new beat is taken before the previous one is through.
// A finished result sits in the output register; if out_stall holds it,
// the next beat is still taken, but its result waits until the held one
// is gone. Configuration is a plain write port (cfg_we, cfg_index, cfg_data);
// the user must use it only while the block is idle; the block does not enforce this.
// Reset puts the pose and stored speeds to zero and the registers to
// time_step 655, axis_reciprocal 65536, max_wheel_speed 4096.
module differential_drive_pose_integrator #(
	parameter int CORDIC_ITERATIONS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic signed [15:0]  cmd_left,
	input  logic signed [15:0]  cmd_right,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [31:0]  pos_x,
	output logic signed [31:0]  pos_y,
	output logic signed [23:0]  heading,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [23:0]         cfg_data
);
	import dpi_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_ROT  = 4'b0010,
		ST_MUL  = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	// register indexes
	localparam logic [1:0] REG_TIME_STEP = 2'd0;
	localparam logic [1:0] REG_AXIS_RECIP = 2'd1;
	localparam logic [1:0] REG_MAX_SPEED = 2'd2;

	// multiply-accumulate steps
	localparam logic [3:0] MS_DIST  = 4'd0;
	localparam logic [3:0] MS_TURN  = 4'd1;
	localparam logic [3:0] MS_XLO   = 4'd2;
	localparam logic [3:0] MS_XHI   = 4'd3;
	localparam logic [3:0] MS_YLO   = 4'd4;
	localparam logic [3:0] MS_YHI   = 4'd5;
	localparam logic [3:0] MS_HLO   = 4'd6;
	localparam logic [3:0] MS_HHI   = 4'd7;
	localparam logic [3:0] MS_HEAD  = 4'd8;

	localparam logic signed [57:0] RND_XY   = 58'sd4294967296;
	localparam logic signed [57:0] RND_HEAD = 58'sd8388608;

	state_t               state_q;
	logic [3:0]           step_q;

	logic [15:0]          time_step_q;
	logic [23:0]          axis_recip_q;
	logic [14:0]          max_speed_q;

	logic signed [31:0]   x_q;
	logic signed [31:0]   y_q;
	logic signed [23:0]   head_q;
	logic signed [15:0]   left_q;
	logic signed [15:0]   right_q;
	logic signed [15:0]   new_left_q;
	logic signed [15:0]   new_right_q;

	logic signed [CW-1:0] c_q;
	logic signed [CW-1:0] s_q;
	logic signed [32:0]   dist_q;
	logic signed [32:0]   t1_q;
	logic signed [57:0]   acc_q;

	logic                 out_valid_q;
	logic signed [31:0]   pos_x_q;
	logic signed [31:0]   pos_y_q;
	logic signed [23:0]   heading_q;

	logic                 in_take;
	logic                 load_out;
	logic                 cor_done;
	sincos_t              cor_res;

	logic signed [16:0]   sum;
	logic signed [16:0]   diff;
	logic signed [17:0]   a_op;
	logic signed [24:0]   b_op;
	logic signed [42:0]   prod;
	logic signed [57:0]   prod_ext;

	logic signed [57:0]   rnd_xy;
	logic signed [24:0]   dpos;
	logic signed [33:0]   pos_sum;
	logic signed [31:0]   pos_new;
	logic signed [57:0]   rnd_head;
	logic signed [33:0]   turn;
	logic signed [34:0]   h_sum;
	logic signed [34:0]   h_fold;
	logic signed [23:0]   head_new;

	function automatic logic signed [15:0] clamp_speed(
		input logic signed [15:0] v,
		input logic [14:0]        m
	);
		logic signed [16:0] vv;
		logic signed [16:0] mp;
		logic signed [16:0] mn;
		logic signed [15:0] r;
		vv = {v[15], v};
		mp = {2'b00, m};
		mn = -mp;
		r  = v;
		if (vv > mp) begin
			r = mp[15:0];
		end else if (vv < mn) begin
			r = mn[15:0];
		end
		return r;
	endfunction

	// handshakes
	assign in_stall = (state_q != ST_IDLE);
	assign in_take  = in_valid && !in_stall;
	assign load_out = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	// sin and cos of the stored heading
	dpi_cordic #(
		.ITERATIONS (CORDIC_ITERATIONS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_take),
		.angle  (head_q),
		.done   (cor_done),
		.result (cor_res)
	);

	// shared multiplier operand select
	assign sum  = {right_q[15], right_q} + {left_q[15], left_q};
	assign diff = {right_q[15], right_q} - {left_q[15], left_q};

	always_comb begin
		a_op = '0;
		b_op = '0;
		unique case (step_q)
			MS_DIST: begin
				a_op = {sum[16], sum};
				b_op = {9'd0, time_step_q};
			end
			MS_TURN: begin
				a_op = {diff[16], diff};
				b_op = {9'd0, time_step_q};
			end
			MS_XLO: begin
				a_op = {1'b0, dist_q[16:0]};
				b_op = {c_q[CW-1], c_q};
			end
			MS_XHI: begin
				a_op = {{2{dist_q[32]}}, dist_q[32:17]};
				b_op = {c_q[CW-1], c_q};
			end
			MS_YLO: begin
				a_op = {1'b0, dist_q[16:0]};
				b_op = {s_q[CW-1], s_q};
			end
			MS_YHI: begin
				a_op = {{2{dist_q[32]}}, dist_q[32:17]};
				b_op = {s_q[CW-1], s_q};
			end
			MS_HLO: begin
				a_op = {1'b0, t1_q[16:0]};
				b_op = {1'b0, axis_recip_q};
			end
			MS_HHI: begin
				a_op = {{2{t1_q[32]}}, t1_q[32:17]};
				b_op = {1'b0, axis_recip_q};
			end
			default: begin
				a_op = '0;
				b_op = '0;
			end
		endcase
	end

	assign prod     = a_op * b_op;
	assign prod_ext = {{15{prod[42]}}, prod};

	// position update: round, add, saturate (x at step YLO, y at step HLO)
	assign rnd_xy  = acc_q + RND_XY;
	assign dpos    = rnd_xy[57:33];
	assign pos_sum = ((step_q == MS_YLO) ? {{2{x_q[31]}}, x_q} : {{2{y_q[31]}}, y_q})
		+ {{9{dpos[24]}}, dpos};

	always_comb begin
		if (pos_sum > 34'sd2147483647) begin
			pos_new = 32'sh7FFFFFFF;
		end else if (pos_sum < -34'sd2147483648) begin
			pos_new = 32'sh80000000;
		end else begin
			pos_new = pos_sum[31:0];
		end
	end

	// heading update: round the turn, fold by 2*pi, saturate
	assign rnd_head = acc_q + RND_HEAD;
	assign turn     = rnd_head[57:24];
	assign h_sum    = {{11{head_q[23]}}, head_q} + {turn[33], turn};

	always_comb begin
		h_fold = h_sum;
		if (h_sum > 35'(ANG_TWO_PI)) begin
			h_fold = h_sum - 35'(ANG_TWO_PI);
		end else if (h_sum < -35'(ANG_TWO_PI)) begin
			h_fold = h_sum + 35'(ANG_TWO_PI);
		end
		if (h_fold > 35'sd8388607) begin
			head_new = 24'sh7FFFFF;
		end else if (h_fold < -35'sd8388608) begin
			head_new = 24'sh800000;
		end else begin
			head_new = h_fold[23:0];
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_step_q  <= 16'd655;
			axis_recip_q <= 24'd65536;
			max_speed_q  <= 15'd4096;
		end else if (cfg_we) begin
			priority case (cfg_index)
				REG_TIME_STEP:  time_step_q  <= cfg_data[15:0];
				REG_AXIS_RECIP: axis_recip_q <= cfg_data;
				REG_MAX_SPEED:  max_speed_q  <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	// sequencer and pose state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			x_q     <= '0;
			y_q     <= '0;
			head_q  <= '0;
			left_q  <= '0;
			right_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						state_q <= ST_ROT;
					end
				end
				ST_ROT: begin
					if (cor_done) begin
						step_q  <= MS_DIST;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					step_q <= step_q + 1'b1;
					if (step_q == MS_YLO) begin
						x_q <= pos_new;
					end
					if (step_q == MS_HLO) begin
						y_q <= pos_new;
					end
					if (step_q == MS_HEAD) begin
						head_q  <= head_new;
						left_q  <= new_left_q;
						right_q <= new_right_q;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_take) begin
			new_left_q  <= clamp_speed(cmd_left, max_speed_q);
			new_right_q <= clamp_speed(cmd_right, max_speed_q);
		end
		if (state_q == ST_ROT && cor_done) begin
			c_q <= cor_res.c;
			s_q <= cor_res.s;
		end
		if (state_q == ST_MUL) begin
			priority case (step_q)
				MS_DIST: dist_q <= prod[32:0];
				MS_TURN: t1_q   <= prod[32:0];
				MS_XLO, MS_YLO, MS_HLO: acc_q <= prod_ext;
				MS_XHI, MS_YHI, MS_HHI: acc_q <= acc_q + (prod_ext <<< 17);
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			pos_x_q   <= x_q;
			pos_y_q   <= y_q;
			heading_q <= head_q;
		end
	end

	assign out_valid = out_valid_q;
	assign pos_x     = pos_x_q;
	assign pos_y     = pos_y_q;
	assign heading   = heading_q;

	// checks
	a_take_starts_rot: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> (state_q == ST_ROT))
		else $error("accepted beat did not start the rotation phase");

	a_cordic_done_in_rot: assert property (@(posedge clk) disable iff (!arst_n)
		cor_done |-> (state_q == ST_ROT))
		else $error("cordic finished outside the rotation phase");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result raised without a finished step");

endmodule
